>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file tgp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TGP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that stays armed through reset.
`define TGP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> hw/rtl/tgp_pkg.sv
// ----------------------------------------------------------------------------
// tgp_pkg: shared definitions for the turtle grid plotter
// Grid geometry, command and heading codes, result type, helper functions.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [3:0] REQ_FWD     = 4'd0;
  localparam logic [3:0] REQ_BACK    = 4'd1;
  localparam logic [3:0] REQ_LEFT    = 4'd2;
  localparam logic [3:0] REQ_RIGHT   = 4'd3;
  localparam logic [3:0] REQ_PENUP   = 4'd4;
  localparam logic [3:0] REQ_PENDOWN = 4'd5;
  localparam logic [3:0] REQ_PENCHAR = 4'd6;
  localparam logic [3:0] REQ_HYPER   = 4'd7;
  localparam logic [3:0] REQ_STOP    = 4'd8;
  localparam logic [3:0] REQ_READ    = 4'd9;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  typedef struct packed {
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [1:0]       heading;
    logic             pen_is_down;
    logic [7:0]       pen_glyph;
    logic [7:0]       cell_value;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
  } canvas_wr_t;

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [15:0] v);
    logic [ROW_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v >= GRID_ROWS) begin
      r = ROW_W'(GRID_ROWS - 1);
    end else begin
      r = v[ROW_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [15:0] v);
    logic [COL_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v >= GRID_COLS) begin
      c = COL_W'(GRID_COLS - 1);
    end else begin
      c = v[COL_W-1:0];
    end
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row * GRID_COLS + col);
  endfunction

endpackage

>>> hw/rtl/tgp_if.sv
// ----------------------------------------------------------------------------
// tgp_if: command and result channels of the turtle grid plotter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tgp_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic [7:0]         step_count;
  logic signed [15:0] target_row;
  logic signed [15:0] target_col;
  logic [7:0]         new_pen_char;

  modport source (output valid, req_type, step_count, target_row, target_col,
                  new_pen_char, input ready);
  modport sink   (input valid, req_type, step_count, target_row, target_col,
                  new_pen_char, output ready);
endinterface

interface tgp_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cur_row;
  logic [5:0] cur_col;
  logic [1:0] heading;
  logic       pen_is_down;
  logic [7:0] pen_glyph;
  logic [7:0] cell_value;

  modport source (output valid, cur_row, cur_col, heading, pen_is_down, pen_glyph,
                  cell_value, input ready);
  modport sink   (input valid, cur_row, cur_col, heading, pen_is_down, pen_glyph,
                  cell_value, output ready);
endinterface

>>> hw/rtl/tgp_canvas.sv
// ----------------------------------------------------------------------------
// tgp_canvas: character grid storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgp_canvas import tgp_pkg::*; (
  input  logic              clk,
  input  canvas_wr_t        wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata_r
);

  logic [7:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hw/rtl/turtle_grid_plotter_core.sv
// ----------------------------------------------------------------------------
// turtle_grid_plotter_core: turtle plotter on a character grid, one command per transfer
// Each command goes IDLE to DONE, via MOVE (nonzero fwd/back) or READ (read cell);
// commands are taken only in IDLE, and a move steps one cell a cycle on the step unit.
// Reset (sync, rst_n low): a clearing pass blanks all 2048 canvas cells first.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_core import tgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tgp_in_if.sink      in_chan,
  tgp_out_if.source   out_chan
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOVE  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        facing_r, facing_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic              pen_dn_r, pen_dn_nxt;
  logic [7:0]        pen_chr_r, pen_chr_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [ROW_W-1:0]  step_row, hyp_row;
  logic [COL_W-1:0]  step_col, hyp_col;
  canvas_wr_t        wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              in_xfer;

  tgp_canvas u_canvas (
    .clk     (clk),
    .wr      (wr),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign hyp_row       = clamp_row(in_chan.target_row);
  assign hyp_col       = clamp_col(in_chan.target_col);
  assign raddr         = cell_addr(hyp_row, hyp_col);

  // single-cell step with wall clamp
  always_comb begin
    step_row = row_r;
    step_col = col_r;
    unique case (dir_r)
      HEAD_NORTH: if (row_r != '0) step_row = row_r - 1'b1;
      HEAD_EAST:  if (col_r != COL_W'(GRID_COLS - 1)) step_col = col_r + 1'b1;
      HEAD_SOUTH: if (row_r != ROW_W'(GRID_ROWS - 1)) step_row = row_r + 1'b1;
      default:    if (col_r != '0) step_col = col_r - 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    facing_nxt    = facing_r;
    dir_nxt       = dir_r;
    pen_dn_nxt    = pen_dn_r;
    pen_chr_nxt   = pen_chr_r;
    cnt_nxt       = cnt_r;
    cell_nxt      = cell_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    wr            = '{we: 1'b0, waddr: cell_addr(step_row, step_col), wdata: pen_chr_r};

    unique case (state_r)
      ST_CLEAR: begin
        wr = '{we: 1'b1, waddr: clr_addr_r, wdata: BLANK_CHAR};
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cell_nxt  = '0;
          state_nxt = ST_DONE;
          unique case (in_chan.req_type)
            REQ_FWD, REQ_BACK: begin
              cnt_nxt = in_chan.step_count;
              dir_nxt = (in_chan.req_type == REQ_FWD) ? facing_r : facing_r + 2'd2;
              if (in_chan.step_count != '0) state_nxt = ST_MOVE;
            end
            REQ_LEFT:    facing_nxt  = facing_r - 2'd1;
            REQ_RIGHT:   facing_nxt  = facing_r + 2'd1;
            REQ_PENUP:   pen_dn_nxt  = 1'b0;
            REQ_PENDOWN: pen_dn_nxt  = 1'b1;
            REQ_PENCHAR: pen_chr_nxt = in_chan.new_pen_char;
            REQ_HYPER: begin
              row_nxt = hyp_row;
              col_nxt = hyp_col;
              wr      = '{we: pen_dn_r, waddr: raddr, wdata: pen_chr_r};
            end
            REQ_READ:    state_nxt = ST_READ;
            default: ;
          endcase
        end
      end
      ST_MOVE: begin
        row_nxt = step_row;
        col_nxt = step_col;
        wr.we   = pen_dn_r;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 8'd1) state_nxt = ST_DONE;
      end
      ST_READ: begin
        cell_nxt  = rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt = '{cur_row: row_r, cur_col: col_r, heading: facing_r,
                      pen_is_down: pen_dn_r, pen_glyph: pen_chr_r, cell_value: cell_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      facing_r    <= HEAD_EAST;
      pen_dn_r    <= 1'b0;
      pen_chr_r   <= BLANK_CHAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      facing_r    <= facing_nxt;
      pen_dn_r    <= pen_dn_nxt;
      pen_chr_r   <= pen_chr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r  <= dir_nxt;
    cell_r <= cell_nxt;
    out_r  <= out_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.cur_row     = out_r.cur_row;
  assign out_chan.cur_col     = out_r.cur_col;
  assign out_chan.heading     = out_r.heading;
  assign out_chan.pen_is_down = out_r.pen_is_down;
  assign out_chan.pen_glyph   = out_r.pen_glyph;
  assign out_chan.cell_value  = out_r.cell_value;

endmodule

>>> hw/rtl/tgp_checker.sv
// ----------------------------------------------------------------------------
// tgp_checker: port-level checks for the turtle grid plotter
// Watches the command and result handshakes of the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a stalled result stays offered
  `TGP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // one command at a time: busy right after a command transfer
  `TGP_ASSERT(a_busy_after_cmd, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // clearing pass follows reset, so no command is taken right after it
  `TGP_ASSERT_NR(a_clear_after_reset, clk, !rst_n |=> !in_ready && !out_valid)

endmodule

bind turtle_grid_plotter_core tgp_checker u_tgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);

>>> test/tb_turtle_grid_plotter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turtle_grid_plotter_core: self-checking bench for the turtle grid plotter
// Drives a directed command list and then 1200 random commands through
// the valid/ready command channel, with random gaps on both channels. A local
// model of the grid and the turtle predicts every status word, and the monitor
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_turtle_grid_plotter_core;
  import tgp_pkg::*;

  localparam int          IDLE_LIMIT   = 20000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          RAND_CMDS    = 1200;
  localparam logic [3:0]  REQ_SPARE_LO = 4'd10;
  localparam logic [3:0]  REQ_SPARE_HI = 4'd15;

  typedef struct {
    logic [3:0]         req;
    logic [7:0]         count;
    logic signed [15:0] trow;
    logic signed [15:0] tcol;
    logic [7:0]         glyph;
    bit                 aim_here;
    int                 gap;
  } plot_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  tgp_in_if  in_if ();
  tgp_out_if out_if ();

  turtle_grid_plotter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // turtle and canvas shadow
  logic [7:0]       canvas_img [CELLS];
  logic [ROW_W-1:0] plot_row     = '0;
  logic [COL_W-1:0] plot_col     = '0;
  logic [1:0]       plot_heading = HEAD_EAST;
  logic             plot_pen     = 1'b0;
  logic [7:0]       plot_glyph   = BLANK_CHAR;

  plot_cmd_t cmd_queue[$];
  out_item_t awaited_status[$];
  plot_cmd_t on_bus;
  int        cmds_total = 0;
  int        cmds_sent  = 0;
  int        error_count = 0;
  int        hold_left  = 0;
  int        stall_left = 0;
  bit        sink_calm  = 1'b0;
  bit        src_calm   = 1'b0;
  int        idle_cycles = 0;

  function automatic int clamp_index(logic signed [15:0] v, int limit);
    if (v < 0) return 0;
    if (int'(v) >= limit) return limit - 1;
    return int'(v);
  endfunction

  function automatic void ink_cell();
    if (plot_pen) canvas_img[int'(plot_row) * GRID_COLS + int'(plot_col)] = plot_glyph;
  endfunction

  function automatic out_item_t plot_command(plot_cmd_t c);
    out_item_t  s;
    logic [1:0] dir;
    logic [7:0] rd_val;
    rd_val = 8'h00;
    case (c.req)
      REQ_FWD, REQ_BACK: begin
        dir = (c.req == REQ_FWD) ? plot_heading : plot_heading + 2'd2;
        for (int i = 0; i < int'(c.count); i++) begin
          case (dir)
            HEAD_NORTH: if (plot_row > 0) plot_row = plot_row - 1'b1;
            HEAD_EAST:  if (int'(plot_col) + 1 < GRID_COLS) plot_col = plot_col + 1'b1;
            HEAD_SOUTH: if (int'(plot_row) + 1 < GRID_ROWS) plot_row = plot_row + 1'b1;
            default:    if (plot_col > 0) plot_col = plot_col - 1'b1;
          endcase
          ink_cell();
        end
      end
      REQ_LEFT:    plot_heading = plot_heading - 2'd1;
      REQ_RIGHT:   plot_heading = plot_heading + 2'd1;
      REQ_PENUP:   plot_pen = 1'b0;
      REQ_PENDOWN: plot_pen = 1'b1;
      REQ_PENCHAR: plot_glyph = c.glyph;
      REQ_HYPER: begin
        plot_row = ROW_W'(clamp_index(c.trow, GRID_ROWS));
        plot_col = COL_W'(clamp_index(c.tcol, GRID_COLS));
        ink_cell();
      end
      REQ_READ: begin
        rd_val = canvas_img[clamp_index(c.trow, GRID_ROWS) * GRID_COLS +
                            clamp_index(c.tcol, GRID_COLS)];
      end
      default: ;
    endcase
    s.cur_row     = plot_row;
    s.cur_col     = plot_col;
    s.heading     = plot_heading;
    s.pen_is_down = plot_pen;
    s.pen_glyph   = plot_glyph;
    s.cell_value  = rd_val;
    return s;
  endfunction

  function automatic int pick_gap();
    int w;
    w = $urandom_range(0, 99);
    if (w < 70) return $urandom_range(1, 3);
    if (w < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v)
      report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, exp_v, got_v));
  endtask

  task automatic add_cmd(logic [3:0] req, int count, int trow, int tcol, int glyph,
                         bit aim_here = 1'b0);
    plot_cmd_t c;
    c.req      = req;
    c.count    = 8'(count);
    c.trow     = 16'(trow);
    c.tcol     = 16'(tcol);
    c.glyph    = 8'(glyph);
    c.aim_here = aim_here;
    if ($urandom_range(0, 79) == 0) src_calm = !src_calm;
    c.gap      = (src_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    cmd_queue.push_back(c);
    cmds_total++;
  endtask

  // command driver
  always @(posedge clk) begin
    plot_cmd_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        awaited_status.push_back(plot_command(on_bus));
        cmds_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (hold_left > 0) begin
          hold_left--;
          in_if.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          if (nxt.aim_here) begin
            nxt.trow = 16'(int'(plot_row) + int'(nxt.trow));
            nxt.tcol = 16'(int'(plot_col) + int'(nxt.tcol));
          end
          on_bus             = nxt;
          in_if.req_type     <= nxt.req;
          in_if.step_count   <= nxt.count;
          in_if.target_row   <= nxt.trow;
          in_if.target_col   <= nxt.tcol;
          in_if.new_pen_char <= nxt.glyph;
          in_if.valid        <= 1'b1;
          hold_left = (cmd_queue.size() > 0) ? cmd_queue[0].gap : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // status monitor
  always @(posedge clk) begin
    out_item_t exp_s;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_status.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          exp_s = awaited_status.pop_front();
          check_field("cur_row",     int'(exp_s.cur_row),     int'(out_if.cur_row));
          check_field("cur_col",     int'(exp_s.cur_col),     int'(out_if.cur_col));
          check_field("heading",     int'(exp_s.heading),     int'(out_if.heading));
          check_field("pen_is_down", int'(exp_s.pen_is_down), int'(out_if.pen_is_down));
          check_field("pen_glyph",   int'(exp_s.pen_glyph),   int'(out_if.pen_glyph));
          check_field("cell_value",  int'(exp_s.cell_value),  int'(out_if.cell_value));
        end
      end
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int w;
    int cnt;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_STOP;
    in_if.step_count   = '0;
    in_if.target_row   = '0;
    in_if.target_col   = '0;
    in_if.new_pen_char = '0;
    out_if.ready       = 1'b0;
    rst_n              = 1'b0;
    for (int i = 0; i < CELLS; i++) canvas_img[i] = BLANK_CHAR;

    // directed: walls, zero counts, clamped targets, spare codes
    add_cmd(REQ_READ,    0, 0, 0, 0);
    add_cmd(REQ_PENDOWN, 0, 0, 0, 0);
    add_cmd(REQ_PENCHAR, 0, 0, 0, 'hFF);
    add_cmd(REQ_FWD,     255, 0, 0, 0);
    add_cmd(REQ_READ,    0, 0, 63, 0);
    add_cmd(REQ_RIGHT,   0, 0, 0, 0);
    add_cmd(REQ_FWD,     0, 0, 0, 0);
    add_cmd(REQ_BACK,    3, 0, 0, 0);
    add_cmd(REQ_FWD,     255, 0, 0, 0);
    add_cmd(REQ_LEFT,    0, 0, 0, 0);
    add_cmd(REQ_LEFT,    0, 0, 0, 0);
    add_cmd(REQ_LEFT,    0, 0, 0, 0);
    add_cmd(REQ_PENUP,   0, 0, 0, 0);
    add_cmd(REQ_PENCHAR, 0, 0, 0, 'h00);
    add_cmd(REQ_HYPER,   0, -32768, 32767, 0);
    add_cmd(REQ_PENDOWN, 0, 0, 0, 0);
    add_cmd(REQ_HYPER,   0, 32767, -32768, 0);
    add_cmd(REQ_READ,    0, 40, -5, 0);
    add_cmd(REQ_STOP,    255, 12, 7, 'hAA);
    add_cmd(REQ_SPARE_LO, 9, 3, 3, 'h55);
    add_cmd(REQ_SPARE_HI, 200, -1, -1, 'hFF);
    add_cmd(REQ_PENUP,   0, 0, 0, 0);
    add_cmd(REQ_BACK,    5, 0, 0, 0);
    add_cmd(REQ_READ,    0, 31, 63, 0);
    add_cmd(REQ_READ,    0, -1, 64, 0);

    for (int n = 0; n < RAND_CMDS; n++) begin
      w = $urandom_range(0, 99);
      if (w < 36) begin
        cnt = $urandom_range(0, 99);
        if (cnt < 70)      cnt = $urandom_range(1, 8);
        else if (cnt < 90) cnt = $urandom_range(9, 40);
        else if (cnt < 97) cnt = 0;
        else               cnt = $urandom_range(200, 255);
        add_cmd($urandom_range(0, 1) ? REQ_FWD : REQ_BACK, cnt,
                $urandom(), $urandom(), $urandom());
      end else if (w < 50) begin
        add_cmd($urandom_range(0, 1) ? REQ_LEFT : REQ_RIGHT, $urandom(),
                $urandom(), $urandom(), $urandom());
      end else if (w < 54) begin
        add_cmd(REQ_PENUP, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (w < 62) begin
        add_cmd(REQ_PENDOWN, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (w < 68) begin
        add_cmd(REQ_PENCHAR, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (w < 76) begin
        cnt = $urandom_range(0, 9);
        if (cnt < 8)
          add_cmd(REQ_HYPER, $urandom(), $urandom_range(0, GRID_ROWS - 1),
                  $urandom_range(0, GRID_COLS - 1), $urandom());
        else if (cnt < 9)
          add_cmd(REQ_HYPER, $urandom(), int'($urandom_range(0, GRID_ROWS + 6)) - 3,
                  int'($urandom_range(0, GRID_COLS + 6)) - 3, $urandom());
        else
          add_cmd(REQ_HYPER, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (w < 79) begin
        add_cmd(REQ_STOP, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (w < 98) begin
        cnt = $urandom_range(0, 19);
        if (cnt < 11)
          add_cmd(REQ_READ, $urandom(), int'($urandom_range(0, 4)) - 2,
                  int'($urandom_range(0, 4)) - 2, $urandom(), 1'b1);
        else if (cnt < 18)
          add_cmd(REQ_READ, $urandom(), $urandom_range(0, GRID_ROWS - 1),
                  $urandom_range(0, GRID_COLS - 1), $urandom());
        else
          add_cmd(REQ_READ, $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        add_cmd(4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), $urandom(),
                $urandom(), $urandom(), $urandom());
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmds_sent == cmds_total);
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_status.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_status.size()));

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
